>>> rtl/core/utrb_pkg.sv
// Shared command and status codes for the UART ring buffer block.
`timescale 1ns / 1ps

package utrb_pkg;

	// Command codes on the command port
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_PUT   = 2'd0;
	localparam cmd_t CMD_GET   = 2'd1;
	localparam cmd_t CMD_EVENT = 2'd2;
	localparam cmd_t CMD_FLUSH = 2'd3;

	// Status codes on the status port
	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

endpackage

>>> rtl/core/uart_tx_rx_ring_buffers.sv
// UART transmit and receive ring buffers with interrupt-enable flags.
//
// Usage: a request (command plus its fields) is taken at a rising edge where
// start is high and busy is low. Commands: put queues put_data on the transmit
// queue, get dequeues one byte from the receive queue, event models one
// interrupt (pop a transmit byte to the line when line_tx_ready, push
// line_rx_data when line_rx_valid), flush drains the whole transmit queue.
// Each result is shown for exactly one cycle with done high; last marks the
// final result of a request. tx_level, rx_level and the irq enables give the
// state after that result.
// Timing: put, get and event give one result in the cycle after the cycle of
// the request's execute step, and busy is high during that step. Flush gives
// one result per queued byte, one per cycle (one result when the queue is
// empty), and busy stays high through its final execute step. Flush streaming
// rests on the single read port of each queue memory, whose read data is
// registered and always prefetches the byte at the read index.
// Reset clears indexes, counts and the transmit enable, and sets the receive
// enable; queue memories are not cleared. The receiver cannot stall: results
// are never held back.
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   command,
	input  logic [7:0]                   put_data,
	input  logic                         line_tx_ready,
	input  logic                         line_rx_valid,
	input  logic [7:0]                   line_rx_data,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [7:0]                   get_data,
	output logic                         send_valid,
	output logic [7:0]                   send_byte,
	output logic                         tx_irq_enable,
	output logic                         rx_irq_enable,
	output logic [$clog2(DEPTH+1)-1:0]   tx_level,
	output logic [$clog2(DEPTH+1)-1:0]   rx_level,
	output logic                         last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] CNT_FULL   = CW'(DEPTH);
	localparam logic [CW-1:0] CNT_ALMOST = CW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_ONE    = CW'(1);
	localparam logic [IW-1:0] IDX_LAST   = IW'(DEPTH - 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic                 state_q;
	utrb_pkg::cmd_t       cmd_q;
	logic [7:0]           put_data_q;
	logic                 tx_ready_q;
	logic                 rx_valid_q;
	logic [7:0]           rx_data_q;

	logic [7:0]           tx_mem [DEPTH];
	logic [7:0]           rx_mem [DEPTH];
	logic [7:0]           tx_rdata_q;
	logic [7:0]           rx_rdata_q;

	logic [IW-1:0]        tx_wr_q, tx_rd_q, rx_wr_q, rx_rd_q;
	logic [CW-1:0]        tx_cnt_q, rx_cnt_q;
	logic                 tx_int_q, rx_int_q;

	logic                 done_q, last_q, send_valid_q;
	utrb_pkg::status_t    status_q;
	logic [7:0]           get_data_q, send_byte_q;

	logic                 run, accept;
	logic                 tx_push, tx_pop, rx_push, rx_pop, finish;
	logic [IW-1:0]        tx_wr_nxt, tx_rd_nxt, rx_wr_nxt, rx_rd_nxt;
	logic [IW-1:0]        tx_raddr, rx_raddr;
	utrb_pkg::status_t    status_d;

	assign run    = (state_q == S_RUN);
	assign busy   = run;
	assign accept = start && !busy;

	// Ring index increments
	assign tx_wr_nxt = (tx_wr_q == IDX_LAST) ? '0 : tx_wr_q + IW'(1);
	assign tx_rd_nxt = (tx_rd_q == IDX_LAST) ? '0 : tx_rd_q + IW'(1);
	assign rx_wr_nxt = (rx_wr_q == IDX_LAST) ? '0 : rx_wr_q + IW'(1);
	assign rx_rd_nxt = (rx_rd_q == IDX_LAST) ? '0 : rx_rd_q + IW'(1);

	// Queue operations of the execute step
	always_comb begin
		tx_push  = 1'b0;
		tx_pop   = 1'b0;
		rx_push  = 1'b0;
		rx_pop   = 1'b0;
		finish   = 1'b0;
		status_d = utrb_pkg::ST_OK;
		if (run) begin
			finish = 1'b1;
			case (cmd_q)
				utrb_pkg::CMD_PUT: begin
					if (tx_cnt_q == CNT_FULL) status_d = utrb_pkg::ST_FULL;
					else tx_push = 1'b1;
				end
				utrb_pkg::CMD_GET: begin
					if (rx_cnt_q == '0) status_d = utrb_pkg::ST_EMPTY;
					else rx_pop = 1'b1;
				end
				utrb_pkg::CMD_EVENT: begin
					tx_pop  = tx_ready_q && (tx_cnt_q != '0);
					rx_push = rx_valid_q && (rx_cnt_q != CNT_FULL);
				end
				utrb_pkg::CMD_FLUSH: begin
					tx_pop = (tx_cnt_q != '0);
					finish = (tx_cnt_q <= CNT_ONE);
				end
				default: begin
					finish = 1'b1;
				end
			endcase
		end
	end

	// Prefetch the next byte when popping so flush streams one per cycle
	assign tx_raddr = tx_pop ? tx_rd_nxt : tx_rd_q;
	assign rx_raddr = rx_pop ? rx_rd_nxt : rx_rd_q;

	// Queue memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (tx_push) tx_mem[tx_wr_q] <= put_data_q;
		tx_rdata_q <= tx_mem[tx_raddr];
	end

	always_ff @(posedge clk) begin
		if (rx_push) rx_mem[rx_wr_q] <= rx_data_q;
		rx_rdata_q <= rx_mem[rx_raddr];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= utrb_pkg::cmd_t'(command);
			put_data_q <= put_data;
			tx_ready_q <= line_tx_ready;
			rx_valid_q <= line_rx_valid;
			rx_data_q  <= line_rx_data;
		end
	end

	// Sequencer, indexes, counts and enables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tx_wr_q  <= '0;
			tx_rd_q  <= '0;
			tx_cnt_q <= '0;
			rx_wr_q  <= '0;
			rx_rd_q  <= '0;
			rx_cnt_q <= '0;
			tx_int_q <= 1'b0;
			rx_int_q <= 1'b1;
			done_q   <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			done_q <= run;
			last_q <= finish;
			if (accept) state_q <= S_RUN;
			else if (finish) state_q <= S_IDLE;

			if (tx_push) begin
				tx_wr_q  <= tx_wr_nxt;
				tx_cnt_q <= tx_cnt_q + CNT_ONE;
				tx_int_q <= 1'b1;
			end
			if (tx_pop) begin
				tx_rd_q  <= tx_rd_nxt;
				tx_cnt_q <= tx_cnt_q - CNT_ONE;
				// only the interrupt path drops the enable on drain
				if (cmd_q == utrb_pkg::CMD_EVENT && tx_cnt_q == CNT_ONE) tx_int_q <= 1'b0;
			end
			if (rx_push) begin
				rx_wr_q  <= rx_wr_nxt;
				rx_cnt_q <= rx_cnt_q + CNT_ONE;
				if (rx_cnt_q == CNT_ALMOST) rx_int_q <= 1'b0;
			end
			if (rx_pop) begin
				rx_rd_q  <= rx_rd_nxt;
				rx_cnt_q <= rx_cnt_q - CNT_ONE;
				if (rx_cnt_q >= CNT_ALMOST) rx_int_q <= 1'b1;
			end
		end
	end

	// Result payload registers
	always_ff @(posedge clk) begin
		if (run) begin
			status_q     <= status_d;
			get_data_q   <= rx_pop ? rx_rdata_q : 8'd0;
			send_valid_q <= tx_pop;
			send_byte_q  <= tx_pop ? tx_rdata_q : 8'd0;
		end
	end

	assign done          = done_q;
	assign last          = last_q;
	assign status        = status_q;
	assign get_data      = get_data_q;
	assign send_valid    = send_valid_q;
	assign send_byte     = send_byte_q;
	assign tx_irq_enable = tx_int_q;
	assign rx_irq_enable = rx_int_q;
	assign tx_level      = tx_cnt_q;
	assign rx_level      = rx_cnt_q;

`ifndef SYNTHESIS
	// An accepted request always runs an execute step
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not start executing");

	// Flush results come back to back until the last one
	a_flush_contig: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |=> done)
		else $error("gap inside a multi-result request");

	// After the final result the block is free again
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> !busy)
		else $error("busy still high after final result");

	// Counts never exceed the queue depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_cnt_q <= CNT_FULL) && (rx_cnt_q <= CNT_FULL))
		else $error("queue count beyond depth");

	// Empty get returns zero data
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == utrb_pkg::ST_EMPTY |-> get_data == 8'd0 && !send_valid)
		else $error("empty get carried data");
`endif

endmodule
